// ===== rtl/core/cma_pkg.sv =====
`timescale 1ns / 1ps

package cma_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RADIUS  = 15;
    localparam int RAD_BITS    = 4;
    localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int IDX_BITS    = $clog2(WIN_DEPTH);
    localparam int CNT_BITS    = $clog2(WIN_DEPTH + 1);
    localparam int SEEN_BITS   = 6;
    localparam int SUM_BITS    = SAMPLE_BITS + 6;
    localparam int MAG_BITS    = SUM_BITS - 1;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_BITS    = 24;
    localparam int RECIP_BITS  = 29;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
    localparam int QSHIFT      = RECIP_SHIFT - FRAC_BITS;
    localparam int X_BITS      = MAG_BITS + FRAC_BITS;
    localparam logic [RAD_BITS-1:0] RADIUS_RESET = RAD_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [CNT_BITS-1:0]           t_cnt;
    typedef logic [IDX_BITS-1:0]           t_idx;
    typedef logic [RECIP_BITS-1:0]         t_recip;

    typedef struct packed {
        t_sum sum;
        t_cnt cnt;
        logic fin;
    } t_div_req;

    // floor(2^28 / n) for window counts 1..31
    function automatic t_recip recip_of(input t_cnt n);
        t_recip r;
        case (n)
            5'd1:    r = 29'd268435456;
            5'd2:    r = 29'd134217728;
            5'd3:    r = 29'd89478485;
            5'd4:    r = 29'd67108864;
            5'd5:    r = 29'd53687091;
            5'd6:    r = 29'd44739242;
            5'd7:    r = 29'd38347922;
            5'd8:    r = 29'd33554432;
            5'd9:    r = 29'd29826161;
            5'd10:   r = 29'd26843545;
            5'd11:   r = 29'd24403223;
            5'd12:   r = 29'd22369621;
            5'd13:   r = 29'd20648881;
            5'd14:   r = 29'd19173961;
            5'd15:   r = 29'd17895697;
            5'd16:   r = 29'd16777216;
            5'd17:   r = 29'd15790320;
            5'd18:   r = 29'd14913080;
            5'd19:   r = 29'd14128181;
            5'd20:   r = 29'd13421772;
            5'd21:   r = 29'd12782640;
            5'd22:   r = 29'd12201611;
            5'd23:   r = 29'd11671106;
            5'd24:   r = 29'd11184810;
            5'd25:   r = 29'd10737418;
            5'd26:   r = 29'd10324440;
            5'd27:   r = 29'd9942053;
            5'd28:   r = 29'd9586980;
            5'd29:   r = 29'd9256395;
            5'd30:   r = 29'd8947848;
            5'd31:   r = 29'd8659208;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/centered_moving_average_unit.sv =====
`timescale 1ns / 1ps

// Centered moving average with shrinking edges. Samples enter through the slave stream
// (tlast marks the final sample of a sequence); each position gets the mean of the samples
// within radius on both sides, clipped at the sequence ends, as a signed value with 8
// fractional bits in m_axis_tdata, tlast set on the mean for the last position. Samples
// sit in a row of 31 shift cells; a sequencer walks the cells to build each window sum
// with one add per cycle unless the output stalls, and feeds a four-stage reciprocal
// divider that returns one mean per cycle unless the output stalls. In steady state each
// sample is accepted and its mean issued before the next sample is taken. The sample that
// completes the first full window is followed by the leading means; a last sample is
// followed by the trailing means (or one mean per sample of a short sequence). The radius
// register may be written at any idle moment and clears the sequence in progress.

module centered_moving_average_unit import cma_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [15:0]         i_s_axis_tdata,    // [15:0] sample
    input  logic                i_s_axis_tlast,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [23:0]         o_m_axis_tdata,    // [23:0] average
    output logic                o_m_axis_tlast,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RAD_BITS-1:0] i_cfg_data         // radius
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_HOLD   = 5'b00100,
        S_GROW   = 5'b01000,
        S_SHRINK = 5'b10000
    } t_seq_state;

    t_seq_state           r_state, n_state;
    logic [RAD_BITS-1:0]  r_radius, n_radius;
    logic [SEEN_BITS-1:0] r_seen, n_seen;
    t_sum                 r_sum, n_sum;
    t_sum                 r_acc, n_acc;
    t_cnt                 r_cnt, n_cnt;
    t_idx                 r_idx, n_idx;
    t_cnt                 r_left, n_left;
    logic                 r_fin, n_fin;

    logic      w_accept, w_en, w_issue, w_full, w_at_edge;
    t_idx      w_two_r, w_rd_addr;
    t_sample   w_sample, w_rd_data;
    t_sum      w_rd_ext, w_new_sum;
    t_cnt      w_len, w_rp1, w_full_cnt;
    t_div_req  w_req;
    logic [AVG_BITS-1:0] w_avg;
    logic      w_out_fin, w_out_valid;

    assign w_sample   = t_sample'(i_s_axis_tdata[SAMPLE_BITS-1:0]);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_en       = !w_out_valid || i_m_axis_tready;
    assign w_two_r    = {r_radius, 1'b0};
    assign w_rd_addr  = (r_state == S_IDLE) ? w_two_r : r_idx;
    assign w_rd_ext   = t_sum'(w_rd_data);
    assign w_full     = r_seen > SEEN_BITS'(w_two_r);
    assign w_at_edge  = r_seen == SEEN_BITS'(w_two_r);
    // oldest sample leaves the running sum once the window is full
    assign w_new_sum  = r_sum + t_sum'(w_sample) - (w_full ? w_rd_ext : t_sum'(0));
    assign w_len      = CNT_BITS'(r_seen) + CNT_BITS'(1);
    assign w_rp1      = CNT_BITS'(r_radius) + CNT_BITS'(1);
    assign w_full_cnt = CNT_BITS'(w_two_r) + CNT_BITS'(1);
    assign w_issue    = (r_state == S_HOLD) || (r_state == S_GROW) || (r_state == S_SHRINK);

    assign w_req.sum  = r_acc;
    assign w_req.cnt  = r_cnt;
    assign w_req.fin  = r_fin && (r_left == CNT_BITS'(1));

    // a register write wins over a sample beat in the same cycle
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready     = (r_state == S_IDLE);

    cma_window u_window (
        .i_clk     (i_clk),
        .i_shift   (w_accept),
        .i_d       (w_sample),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    cma_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_req_valid (w_issue),
        .i_req       (w_req),
        .o_valid     (w_out_valid),
        .o_avg       (w_avg),
        .o_fin       (w_out_fin)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = w_avg;
    assign o_m_axis_tlast  = w_out_fin;

    always_comb begin
        n_state  = r_state;
        n_radius = r_radius;
        n_seen   = r_seen;
        n_sum    = r_sum;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_left   = r_left;
        n_fin    = r_fin;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_radius = i_cfg_data;
                    n_seen   = '0;
                    n_sum    = '0;
                end else if (w_accept) begin
                    if (i_s_axis_tlast) begin
                        n_seen = '0;
                        n_sum  = '0;
                    end else begin
                        n_seen = (r_seen != '1) ? r_seen + SEEN_BITS'(1) : r_seen;
                        n_sum  = w_new_sum;
                    end
                    n_acc = w_new_sum;
                    if (!w_full && i_s_axis_tlast) begin
                        // short sequence: every position gets the overall mean
                        n_state = S_HOLD;
                        n_cnt   = w_len;
                        n_left  = w_len;
                        n_fin   = 1'b1;
                    end else if (!w_full && w_at_edge) begin
                        n_state = (r_radius == '0) ? S_GROW : S_PREP;
                        n_cnt   = w_rp1;
                        n_left  = w_rp1;
                        n_idx   = '0;
                        n_fin   = 1'b0;
                    end else if (w_full && i_s_axis_tlast) begin
                        n_state = S_SHRINK;
                        n_cnt   = w_full_cnt;
                        n_left  = w_rp1;
                        n_idx   = w_two_r;
                        n_fin   = 1'b1;
                    end else if (w_full) begin
                        n_state = S_HOLD;
                        n_cnt   = w_full_cnt;
                        n_left  = CNT_BITS'(1);
                        n_fin   = 1'b0;
                    end
                end
            end
            S_PREP: begin
                // strip the newest radius samples to reach the first leading window
                n_acc = r_acc - w_rd_ext;
                if (r_idx == IDX_BITS'(r_radius) - IDX_BITS'(1)) begin
                    n_state = S_GROW;
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            S_HOLD: begin
                if (w_en) begin
                    n_left = r_left - CNT_BITS'(1);
                    if (r_left == CNT_BITS'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_GROW: begin
                if (w_en) begin
                    n_acc  = r_acc + w_rd_ext;
                    n_cnt  = r_cnt + CNT_BITS'(1);
                    n_idx  = r_idx - IDX_BITS'(1);
                    n_left = r_left - CNT_BITS'(1);
                    if (r_left == CNT_BITS'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHRINK: begin
                if (w_en) begin
                    n_acc  = r_acc - w_rd_ext;
                    n_cnt  = r_cnt - CNT_BITS'(1);
                    n_idx  = r_idx - IDX_BITS'(1);
                    n_left = r_left - CNT_BITS'(1);
                    if (r_left == CNT_BITS'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= RADIUS_RESET;
            r_seen   <= '0;
            r_sum    <= '0;
            r_left   <= '0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_radius <= n_radius;
            r_seen   <= n_seen;
            r_sum    <= n_sum;
            r_left   <= n_left;
            r_fin    <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

endmodule

// ===== rtl/core/cma_cell.sv =====
`timescale 1ns / 1ps

module cma_cell import cma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_sample i_d,
    output t_sample o_q
);

    t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/core/cma_window.sv =====
`timescale 1ns / 1ps

module cma_window import cma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_sample i_d,
    input  t_idx    i_rd_addr,
    output t_sample o_rd_data
);

    t_sample w_tap [WIN_DEPTH];

    // cell 0 holds the newest sample
    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            cma_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (i_d),
                .o_q     (w_tap[k])
            );
        end else begin : g_body
            cma_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (w_tap[k-1]),
                .o_q     (w_tap[k])
            );
        end
    end

    assign o_rd_data = (i_rd_addr < IDX_BITS'(WIN_DEPTH)) ? w_tap[i_rd_addr] : '0;

endmodule

// ===== rtl/core/cma_div.sv =====
`timescale 1ns / 1ps

module cma_div import cma_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_req_valid,
    input  t_div_req            i_req,
    output logic                o_valid,
    output logic [AVG_BITS-1:0] o_avg,
    output logic                o_fin
);

    logic                 r1_valid, r2_valid, r3_valid, r4_valid;
    logic [MAG_BITS-1:0]  r1_mag, r2_mag;
    logic                 r1_neg, r2_neg;
    t_cnt                 r1_cnt, r2_cnt, r3_cnt;
    logic                 r1_fin, r2_fin, r3_fin, r4_fin;
    t_recip               r1_recip;
    logic [PROD_BITS-1:0] r2_prod;
    logic [X_BITS-1:0]    r3_x, r3_qn;
    logic [AVG_BITS-1:0]  r3_qa, r3_qb, r4_avg;

    logic [MAG_BITS-1:0]  w_mag;
    logic [AVG_BITS-1:0]  w_qest;
    logic [X_BITS-1:0]    w_rem;
    logic                 w_ge;

    assign w_mag  = i_req.sum[SUM_BITS-1] ? MAG_BITS'(-i_req.sum) : MAG_BITS'(i_req.sum);
    // reciprocal estimate is exact or one short
    assign w_qest = r2_prod[QSHIFT +: AVG_BITS];
    assign w_rem  = r3_x - r3_qn;
    assign w_ge   = w_rem >= X_BITS'(r3_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_req_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= w_mag;
            r1_neg   <= i_req.sum[SUM_BITS-1];
            r1_cnt   <= i_req.cnt;
            r1_fin   <= i_req.fin;
            r1_recip <= recip_of(i_req.cnt);

            r2_prod  <= PROD_BITS'(r1_mag) * PROD_BITS'(r1_recip);
            r2_mag   <= r1_mag;
            r2_neg   <= r1_neg;
            r2_cnt   <= r1_cnt;
            r2_fin   <= r1_fin;

            r3_x     <= {r2_mag, FRAC_BITS'(0)};
            r3_qn    <= X_BITS'(w_qest) * X_BITS'(r2_cnt);
            // the estimate and the estimate plus one, negated for a negative sum
            r3_qa    <= r2_neg ? -w_qest : w_qest;
            r3_qb    <= r2_neg ? ~w_qest : w_qest + AVG_BITS'(1);
            r3_cnt   <= r2_cnt;
            r3_fin   <= r2_fin;

            r4_avg   <= w_ge ? r3_qb : r3_qa;
            r4_fin   <= r3_fin;
        end
    end

    assign o_valid = r4_valid;
    assign o_avg   = r4_avg;
    assign o_fin   = r4_fin;

endmodule
